// File: rtl/hhp_pkg.sv
// shared constants, types and helper functions of the heavy-hitter table
`timescale 1ns / 1ps
package hhp_pkg;

    localparam int STAGES          = 10;
    localparam int SLOT_W          = 10;
    localparam int SLOTS_PER_STAGE = 1 << SLOT_W;
    localparam int STAGE_W         = $clog2(STAGES);
    localparam int ADDR_W          = STAGE_W + SLOT_W;
    localparam int TABLE_DEPTH     = STAGES * SLOTS_PER_STAGE;
    localparam int KEY_W           = 32;
    localparam int CNT_W           = 32;
    localparam int ENTRY_W         = KEY_W + CNT_W;
    localparam int CRC_W           = 32;
    localparam int BYTE_W          = 8;
    localparam int WORD_BYTES      = KEY_W / BYTE_W;
    localparam int BYTES_W         = $clog2(WORD_BYTES);

    localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_XOROUT = 32'hFFFF_FFFF;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_QUERY  = 1'b1
    } t_req;

    typedef struct packed {
        logic ready;   // idle, table cleared, can take a request
        logic done;    // result held, waiting for the output register
    } t_eng_stat;

    // one byte of reflected crc-32, bit by bit
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// File: rtl/hashpipe_heavy_hitter_table.sv
// top level of the multi-stage heavy-hitter table with config and output register
`timescale 1ns / 1ps
// The slave stream takes requests: tuser selects insert (0) or query (1), tdata holds
// the 32-bit key. The master stream returns one word per request: the estimated count
// for a query, zero for an insert. The user must write hash_seed through i_cfg_we/i_cfg_wdata
// only while no request is in flight; the block itself does not enforce this.
// Each stage runs the rest of the byte-serial crc (the first byte overlaps the previous
// stage's update), then one table read and one update on the ram.
// A query walks all 10 stages before its result appears on o_m_tvalid; an insert stops
// early on a match or an empty evicted entry.
// One request is in flight at a time: the engine takes no new one until the last has left it.
// After reset the table ram is cleared one entry per cycle, all 10240 entries, during
// which o_s_tready stays low; the seed resets to zero.
// The result sits in an output register; the engine can take the next request while
// it waits. If the receiver stalls and a second result is finished, the engine holds
// it and stays not ready until the output register frees up.
module hashpipe_heavy_hitter_table
    import hhp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [KEY_W-1:0] i_cfg_wdata,   // hash_seed
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [KEY_W-1:0] i_s_tdata,     // [31:0] flow_key
    input  logic             i_s_tuser,     // [0] req_type
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [CNT_W-1:0] o_m_tdata      // [31:0] estimate
);

    logic [KEY_W-1:0] r_seed;
    logic             r_m_tvalid;
    logic [CNT_W-1:0] r_m_tdata;

    t_eng_stat        eng_stat;
    logic [CNT_W-1:0] eng_estimate;
    logic             s_acc;
    logic             take;

    assign o_s_tready = eng_stat.ready;
    assign s_acc      = i_s_tvalid && eng_stat.ready;
    assign take       = eng_stat.done && (!r_m_tvalid || i_m_tready);

    hhp_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_acc),
        .i_type     (t_req'(i_s_tuser)),
        .i_key      (i_s_tdata),
        .i_seed     (r_seed),
        .i_take     (take),
        .o_stat     (eng_stat),
        .o_estimate (eng_estimate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (take) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
        if (take) begin
            r_m_tdata <= eng_estimate;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

`ifndef ASSERT_OFF
    // an accepted request keeps the engine busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("engine ready right after accepting a request");

    // the engine is never idle and holding a result at once
    a_ready_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(eng_stat.ready && eng_stat.done))
        else $error("engine ready while a result is pending");

    // a new output word only comes from a finished engine
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(eng_stat.done))
        else $error("output word without a finished request");

    // a finished result is handed over whenever the output register is free
    a_take_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eng_stat.done && !o_m_tvalid) |=> o_m_tvalid)
        else $error("result not moved into a free output register");
`endif

endmodule

// File: rtl/hhp_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module hhp_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/hhp_crc.sv
// byte-serial crc-32 unit, one byte per cycle, used for every stage hash
`timescale 1ns / 1ps
module hhp_crc
    import hhp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_word,
    output logic             o_done,
    output logic [CRC_W-1:0] o_crc
);

    logic [CRC_W-1:0]        r_crc,  n_crc;
    logic [KEY_W-BYTE_W-1:0] r_word, n_word;
    logic [BYTES_W-1:0]      r_left, n_left;
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;

    always_comb begin
        n_crc  = r_crc;
        n_word = r_word;
        n_left = r_left;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            // first byte goes in right away
            n_crc  = crc_byte(CRC_INIT, i_word[BYTE_W-1:0]);
            n_word = i_word[KEY_W-1:BYTE_W];
            n_left = BYTES_W'(WORD_BYTES - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_crc  = crc_byte(r_crc, r_word[BYTE_W-1:0]);
            n_word = r_word >> BYTE_W;
            n_left = r_left - 1'b1;
            if (r_left == BYTES_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_left <= n_left;
        end
        r_crc  <= n_crc;
        r_word <= n_word;
    end

    assign o_done = r_done;
    assign o_crc  = r_crc ^ CRC_XOROUT;

endmodule

// File: rtl/hhp_engine.sv
// sequencer that walks the stages through the shared hash unit and table ram
`timescale 1ns / 1ps
module hhp_engine
    import hhp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_req             i_type,
    input  logic [KEY_W-1:0] i_key,
    input  logic [KEY_W-1:0] i_seed,
    input  logic             i_take,
    output t_eng_stat        o_stat,
    output logic [CNT_W-1:0] o_estimate
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_UPD   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_clr,   n_clr;
    logic [STAGE_W-1:0] r_stage, n_stage;
    t_req               r_type,  n_type;
    logic [KEY_W-1:0]   r_key,   n_key;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [CNT_W-1:0]   r_sum,   n_sum;
    logic [KEY_W-1:0]   r_sseed, n_sseed;
    logic [ADDR_W-1:0]  r_addr,  n_addr;

    logic               crc_start;
    logic [KEY_W-1:0]   crc_word;
    logic               crc_done;
    logic [CRC_W-1:0]   crc_val;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [KEY_W-1:0]   rd_key;
    logic [CNT_W-1:0]   rd_cnt;
    logic               hit, swap, last, fin;

    hhp_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (crc_start),
        .i_word  (crc_word),
        .o_done  (crc_done),
        .o_crc   (crc_val)
    );

    // entry layout: count in the upper half, key in the lower half
    hhp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[KEY_W-1:0];
    assign rd_cnt = ram_rdata[ENTRY_W-1:KEY_W];
    assign hit    = (rd_key == r_key);
    // stage 0 always takes the new key
    assign swap   = (r_stage == '0) || (r_cnt > rd_cnt);
    assign last   = (r_stage == STAGE_W'(STAGES - 1));

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_stage   = r_stage;
        n_type    = r_type;
        n_key     = r_key;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_sseed   = r_sseed;
        n_addr    = r_addr;
        crc_start = 1'b0;
        crc_word  = i_key ^ i_seed;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = {r_stage, crc_val[SLOT_W-1:0]};
        fin       = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == ADDR_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    crc_start = 1'b1;
                    n_type    = i_type;
                    n_key     = i_key;
                    n_cnt     = CNT_W'(1);
                    n_sum     = '0;
                    n_stage   = '0;
                    n_sseed   = i_seed + 1'b1;
                    n_state   = S_HASH;
                end
            end
            S_HASH: begin
                if (crc_done) begin
                    ram_re  = 1'b1;
                    n_addr  = ram_raddr;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_type == REQ_QUERY) begin
                    if (hit) begin
                        n_sum = sat_add(r_sum, rd_cnt);
                    end
                    fin = last;
                end else if (hit) begin
                    ram_we    = 1'b1;
                    ram_wdata = {sat_add(rd_cnt, r_cnt), rd_key};
                    fin       = 1'b1;
                end else if (swap) begin
                    ram_we    = 1'b1;
                    ram_wdata = {r_cnt, r_key};
                    n_key     = rd_key;
                    n_cnt     = rd_cnt;
                    // an empty evicted entry ends the walk
                    fin       = last || (rd_cnt == '0);
                end else begin
                    fin = last;
                end

                if (fin) begin
                    n_state = S_DONE;
                end else begin
                    crc_start = 1'b1;
                    crc_word  = n_key ^ r_sseed;
                    n_sseed   = r_sseed + 1'b1;
                    n_stage   = r_stage + 1'b1;
                    n_state   = S_HASH;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_stage <= n_stage;
        r_type  <= n_type;
        r_key   <= n_key;
        r_cnt   <= n_cnt;
        r_sum   <= n_sum;
        r_sseed <= n_sseed;
        r_addr  <= n_addr;
    end

    assign o_stat.ready = (r_state == S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_estimate   = r_sum;

endmodule
